FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every use relies on the enclosing
// module having a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define PLC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define PLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/plc_pkg.sv
`default_nettype none
package plc_pkg;

	localparam int INTEN_W = 17;
	localparam int VEC_W   = 16;
	localparam int R_W     = 20;
	localparam int ACC_W   = 40;
	localparam int MA_W    = 36;
	localparam int MB_W    = 20;
	localparam int P_W     = MA_W + MB_W;
	localparam int SQ_W    = 40;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int NUM_W   = 52;
	localparam int DEN_W   = 36;
	localparam int SUM_W   = INTEN_W + 1;

	localparam logic [INTEN_W-1:0] Q16_ONE = 17'h10000;

	typedef enum logic [2:0] {
		OP_POINT   = 3'd0,
		OP_NORMAL  = 3'd1,
		OP_VIEW    = 3'd2,
		OP_AMBIENT = 3'd3,
		OP_LIGHT   = 3'd4
	} plc_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FIT,
		S_SELFDOT,
		S_SELFSQRT,
		S_LDOT,
		S_LSQRT,
		S_NLDOT,
		S_DDEN,
		S_DDIV,
		S_DTERM,
		S_DADD,
		S_SCHK,
		S_RMUL,
		S_RDIV,
		S_RRDOT,
		S_RSQRT,
		S_RVDOT,
		S_SDEN,
		S_SDIV,
		S_PSQ,
		S_PSQW,
		S_PMC,
		S_PMCW,
		S_STERM,
		S_SADD,
		S_ACC
	} plc_state_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] radicand;
	} plc_sqrt_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} plc_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} plc_unit_sts_t;

endpackage
`default_nettype wire

FILE: rtl/plc_isqrt.sv
`default_nettype none
`include "assert_macros.svh"
module plc_isqrt (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  plc_pkg::plc_sqrt_req_t       req,
	output plc_pkg::plc_unit_sts_t       sts,
	output logic [plc_pkg::ROOT_W-1:0]   root
);
	import plc_pkg::*;

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W:0]   r_q;
	logic [SQ_W:0]   trial;
	logic            busy_q;
	logic            done_q;

	assign trial = r_q + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q & bit_q[0];
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// One result bit per cycle; the trial bit walks down two places at a time.
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[SQ_W-1:0];
				r_q <= (r_q >> 1) + {1'b0, bit_q};
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = r_q[ROOT_W-1:0];

	`PLC_ASSERT(a_sqrt_start_idle, req.start |-> !busy_q, "square root restarted while busy")

endmodule
`default_nettype wire

FILE: rtl/plc_div.sv
`default_nettype none
`include "assert_macros.svh"
module plc_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  plc_pkg::plc_div_req_t       req,
	output plc_pkg::plc_unit_sts_t      sts,
	output logic [plc_pkg::NUM_W-1:0]   quot
);
	import plc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] nq_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Restoring division: the numerator shifts out at the top while the
	// quotient bits shift in at the bottom of the same register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = nq_q;

	`PLC_ASSERT(a_div_start_idle, req.start |-> !busy_q, "divider restarted while busy")

endmodule
`default_nettype wire

FILE: rtl/phong_light_accumulate.sv
`default_nettype none
`include "assert_macros.svh"
// Phong lighting accumulator for one surface point. Transactions with op 0, 1 and 2 load the
// point, the normal and the view direction (with the specular exponent); op 3 adds an ambient
// intensity and op 4 a point light, whose diffuse and specular terms are formed in Q1.16 by one
// shared multiplier, an iterative square root (one result bit a cycle) and a restoring divider (one
// quotient bit a cycle) under a sequencer; the input is stalled meanwhile.
// A normal, view or light vector is first shifted down one bit at a time until its largest
// component fits below bit 15. A shadowed light adds nothing; an unshadowed one forms the
// diffuse term (skipped when N.L is not positive) and, with a non-zero exponent, the reflected
// vector and cosine, the power one exponent bit at a time and then the specular term. On an
// ambient or light transaction flagged last the clamped sum is sent and then cleared.
module phong_light_accumulate #(
	parameter int COORD_BITS = 32,
	parameter int EXP_BITS   = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [2:0]                    op,
	input  wire logic signed [COORD_BITS-1:0]  coord_x,
	input  wire logic signed [COORD_BITS-1:0]  coord_y,
	input  wire logic signed [COORD_BITS-1:0]  coord_z,
	input  wire logic [plc_pkg::INTEN_W-1:0]   light_intensity,
	input  wire logic [EXP_BITS-1:0]           specular_exp,
	input  wire logic                          shadowed,
	input  wire logic                          last_light,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [plc_pkg::INTEN_W-1:0]        total_intensity
);
	import plc_pkg::*;

	localparam int FW     = COORD_BITS + 1;
	localparam int PIDX_W = $clog2(EXP_BITS);

	plc_state_t state_q, state_d;
	logic [1:0] k_q;
	logic [1:0] e;
	logic       accept;
	logic       out_free;

	logic signed [COORD_BITS-1:0] coord [3];
	logic signed [COORD_BITS-1:0] point_q [3];
	logic signed [FW-1:0]         cin [3];
	logic signed [FW-1:0]         fsrc [3];
	logic [FW-1:0]                fmag [3];
	logic [2:0]                   fsgn;
	logic [FW-1:0]                fm_q [3];
	logic [2:0]                   fs_q;
	logic                         fit_more;
	logic signed [VEC_W-1:0]      fpos [3];
	logic signed [VEC_W-1:0]      fv [3];

	logic signed [VEC_W-1:0] n_q [3];
	logic signed [VEC_W-1:0] v_q [3];
	logic signed [VEC_W-1:0] l_q [3];
	logic signed [R_W-1:0]   r_q [3];
	logic [DEN_W-1:0]        nn_q;
	logic [ROOT_W-1:0]       nlen_q, vlen_q, llen_q, rlen_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [P_W-1:0]   prod_q;
	logic [P_W-1:0]          pm;
	logic signed [MA_W-1:0]  nl_q, rv_q;
	logic                    dz_q;
	logic [INTEN_W-1:0]      cos_q, pow_q, inten_q, rnd, cosv;
	logic [SUM_W-1:0]        sum_q;
	logic [INTEN_W-1:0]      accum_q;
	logic [EXP_BITS-1:0]     spec_q;
	logic                    last_q;
	plc_op_t                 op_q;
	logic [1:0]              ridx_q;
	logic [PIDX_W-1:0]       pidx_q;
	logic                    res_valid_q;
	logic [INTEN_W-1:0]      res_q;
	logic [SUM_W:0]          tsum;
	logic [INTEN_W-1:0]      tclamp;
	logic signed [R_W-1:0]   qs, rq;

	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic                   mul_en;
	plc_sqrt_req_t          sqrt_req;
	plc_div_req_t           div_req;
	plc_unit_sts_t          sqrt_sts, div_sts;
	logic [ROOT_W-1:0]      root;
	logic [NUM_W-1:0]       quot;

	plc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sqrt_req),
		.sts      (sqrt_sts),
		.root     (root)
	);

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.sts      (div_sts),
		.quot     (quot)
	);

	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	assign item_stall      = (state_q != S_IDLE);
	assign accept          = item_valid && !item_stall;
	assign out_free        = !res_valid_q || !result_stall;
	assign result_valid    = res_valid_q;
	assign total_intensity = res_q;

	// Magnitude and sign of the vector to be scaled down, taken at the input.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cin[i]  = FW'(coord[i]);
			fsrc[i] = (op == OP_LIGHT) ? (cin[i] - FW'(point_q[i])) : cin[i];
			fmag[i] = fsrc[i][FW-1] ? FW'(-fsrc[i]) : FW'(fsrc[i]);
			fsgn[i] = (op == OP_VIEW) ? !fsrc[i][FW-1] : fsrc[i][FW-1];
			fpos[i] = signed'({1'b0, fm_q[i][14:0]});
			fv[i]   = fs_q[i] ? -fpos[i] : fpos[i];
		end
	end

	assign fit_more = (|fm_q[0][FW-1:15]) | (|fm_q[1][FW-1:15]) | (|fm_q[2][FW-1:15]);

	assign e      = (k_q == 2'd3) ? 2'd0 : k_q;
	assign rnd    = INTEN_W'((prod_q[33:0] + 34'd32768) >> 16);
	assign cosv   = dz_q ? '0 : ((quot > NUM_W'(Q16_ONE)) ? Q16_ONE : quot[INTEN_W-1:0]);
	assign pm     = prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);
	assign qs     = signed'(R_W'(quot));
	assign rq     = (nn_q == '0) ? '0 : (prod_q[P_W-1] ? -qs : qs);
	assign tsum   = (SUM_W + 1)'(accum_q) + (SUM_W + 1)'(sum_q);
	assign tclamp = (tsum > (SUM_W + 1)'(Q16_ONE)) ? Q16_ONE : tsum[INTEN_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (plc_op_t'(op))
						OP_NORMAL, OP_VIEW: state_d = S_FIT;
						OP_AMBIENT:         state_d = S_ACC;
						OP_LIGHT:           state_d = shadowed ? S_ACC : S_FIT;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_FIT: begin
				if (!fit_more) begin
					state_d = (op_q == OP_LIGHT) ? S_LDOT : S_SELFDOT;
				end
			end
			S_SELFDOT:  if (k_q == 2'd3) state_d = S_SELFSQRT;
			S_SELFSQRT: if (k_q != 2'd0 && sqrt_sts.done) state_d = S_IDLE;
			S_LDOT:     if (k_q == 2'd3) state_d = S_LSQRT;
			S_LSQRT:    if (k_q != 2'd0 && sqrt_sts.done) state_d = S_NLDOT;
			S_NLDOT:    if (k_q == 2'd3) state_d = S_DDEN;
			S_DDEN: begin
				state_d = (!acc_q[ACC_W-1] && acc_q != '0) ? S_DDIV : S_SCHK;
			end
			S_DDIV:     if (k_q != 2'd0 && div_sts.done) state_d = S_DTERM;
			S_DTERM:    state_d = S_DADD;
			S_DADD:     state_d = S_SCHK;
			S_SCHK:     state_d = (spec_q == '0) ? S_ACC : S_RMUL;
			S_RMUL:     state_d = S_RDIV;
			S_RDIV: begin
				if (k_q != 2'd0 && div_sts.done) begin
					state_d = (ridx_q == 2'd2) ? S_RRDOT : S_RMUL;
				end
			end
			S_RRDOT:    if (k_q == 2'd3) state_d = S_RSQRT;
			S_RSQRT:    if (k_q != 2'd0 && sqrt_sts.done) state_d = S_RVDOT;
			S_RVDOT:    if (k_q == 2'd3) state_d = S_SDEN;
			S_SDEN: begin
				state_d = (!acc_q[ACC_W-1] && acc_q != '0) ? S_SDIV : S_ACC;
			end
			S_SDIV:     if (k_q != 2'd0 && div_sts.done) state_d = S_PSQ;
			S_PSQ:      state_d = S_PSQW;
			S_PSQW: begin
				if (spec_q[pidx_q]) begin
					state_d = S_PMC;
				end else begin
					state_d = (pidx_q == '0) ? S_STERM : S_PSQ;
				end
			end
			S_PMC:      state_d = S_PMCW;
			S_PMCW:     state_d = (pidx_q == '0) ? S_STERM : S_PSQ;
			S_STERM:    state_d = S_SADD;
			S_SADD:     state_d = S_ACC;
			S_ACC:      if (!last_q || out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier and the iterative units.
	always_comb begin
		ma               = '0;
		mb               = '0;
		mul_en           = 1'b0;
		sqrt_req.start   = 1'b0;
		sqrt_req.radicand = acc_q[SQ_W-1:0];
		div_req.start    = 1'b0;
		div_req.num      = '0;
		div_req.den      = prod_q[DEN_W-1:0];
		case (state_q)
			S_SELFDOT: begin
				mul_en = (k_q != 2'd3);
				if (op_q == OP_NORMAL) begin
					ma = MA_W'(n_q[e]);
					mb = MB_W'(n_q[e]);
				end else begin
					ma = MA_W'(v_q[e]);
					mb = MB_W'(v_q[e]);
				end
			end
			S_LDOT: begin
				mul_en = (k_q != 2'd3);
				ma     = MA_W'(l_q[e]);
				mb     = MB_W'(l_q[e]);
			end
			S_NLDOT: begin
				mul_en = (k_q != 2'd3);
				ma     = MA_W'(n_q[e]);
				mb     = MB_W'(l_q[e]);
			end
			S_RRDOT: begin
				mul_en = (k_q != 2'd3);
				ma     = MA_W'(r_q[e]);
				mb     = MB_W'(r_q[e]);
			end
			S_RVDOT: begin
				mul_en = (k_q != 2'd3);
				ma     = MA_W'(r_q[e]);
				mb     = MB_W'(v_q[e]);
			end
			S_SELFSQRT, S_LSQRT, S_RSQRT: begin
				sqrt_req.start = (k_q == 2'd0);
			end
			S_DDEN: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(nlen_q));
				mb     = signed'(MB_W'(llen_q));
			end
			S_DDIV: begin
				div_req.start = (k_q == 2'd0);
				div_req.num   = NUM_W'(unsigned'(nl_q)) << 16;
			end
			S_DTERM: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(inten_q));
				mb     = signed'(MB_W'(cos_q));
			end
			S_RMUL: begin
				mul_en = 1'b1;
				ma     = nl_q;
				mb     = MB_W'(n_q[ridx_q]);
			end
			S_RDIV: begin
				div_req.start = (k_q == 2'd0);
				div_req.num   = {pm[NUM_W-2:0], 1'b0};
				div_req.den   = nn_q;
			end
			S_SDEN: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(rlen_q));
				mb     = signed'(MB_W'(vlen_q));
			end
			S_SDIV: begin
				div_req.start = (k_q == 2'd0);
				div_req.num   = NUM_W'(unsigned'(rv_q)) << 16;
			end
			S_PSQ: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(pow_q));
				mb     = signed'(MB_W'(pow_q));
			end
			S_PMC: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(pow_q));
				mb     = signed'(MB_W'(cos_q));
			end
			S_STERM: begin
				mul_en = 1'b1;
				ma     = signed'(MA_W'(inten_q));
				mb     = signed'(MB_W'(pow_q));
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Sequencer and the state that persists between transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			res_valid_q <= 1'b0;
			nn_q        <= '0;
			nlen_q      <= '0;
			vlen_q      <= '0;
			spec_q      <= '0;
			accum_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				point_q[i] <= '0;
				n_q[i]     <= '0;
				v_q[i]     <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				k_q <= '0;
			end else if (k_q != 2'd3) begin
				k_q <= k_q + 1'b1;
			end

			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && op == OP_POINT) begin
						for (int i = 0; i < 3; i++) begin
							point_q[i] <= coord[i];
						end
					end
					if (accept && op == OP_VIEW) begin
						spec_q <= specular_exp;
					end
				end
				S_FIT: begin
					if (!fit_more && op_q == OP_NORMAL) begin
						for (int i = 0; i < 3; i++) begin
							n_q[i] <= fv[i];
						end
					end
					if (!fit_more && op_q == OP_VIEW) begin
						for (int i = 0; i < 3; i++) begin
							v_q[i] <= fv[i];
						end
					end
				end
				S_SELFSQRT: begin
					if (k_q == 2'd0 && op_q == OP_NORMAL) begin
						nn_q <= acc_q[DEN_W-1:0];
					end
					if (k_q != 2'd0 && sqrt_sts.done) begin
						if (op_q == OP_NORMAL) begin
							nlen_q <= root;
						end else begin
							vlen_q <= root;
						end
					end
				end
				S_ACC: begin
					if (!last_q) begin
						accum_q <= tclamp;
					end else if (out_free) begin
						accum_q     <= '0;
						res_valid_q <= 1'b1;
					end
				end
				default: begin
					accum_q <= accum_q;
				end
			endcase
		end
	end

	// Working registers of one transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			inten_q <= light_intensity;
			last_q  <= last_light;
			op_q    <= plc_op_t'(op);
			sum_q   <= (op == OP_AMBIENT) ? SUM_W'(light_intensity) : '0;
			fs_q    <= fsgn;
			for (int i = 0; i < 3; i++) begin
				fm_q[i] <= fmag[i];
			end
		end

		if (mul_en) begin
			prod_q <= ma * mb;
		end

		case (state_q)
			S_FIT: begin
				if (fit_more) begin
					for (int i = 0; i < 3; i++) begin
						fm_q[i] <= fm_q[i] >> 1;
					end
				end else if (op_q == OP_LIGHT) begin
					for (int i = 0; i < 3; i++) begin
						l_q[i] <= fv[i];
					end
				end
			end
			S_SELFDOT, S_LDOT, S_NLDOT, S_RRDOT, S_RVDOT: begin
				if (k_q == 2'd0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_q + signed'(prod_q[ACC_W-1:0]);
				end
			end
			S_LSQRT: begin
				if (k_q != 2'd0 && sqrt_sts.done) begin
					llen_q <= root;
				end
			end
			S_RSQRT: begin
				if (k_q != 2'd0 && sqrt_sts.done) begin
					rlen_q <= root;
				end
			end
			S_DDEN: begin
				nl_q <= acc_q[MA_W-1:0];
			end
			S_DDIV: begin
				if (k_q == 2'd0) begin
					dz_q <= (prod_q[DEN_W-1:0] == '0);
				end else if (div_sts.done) begin
					cos_q <= cosv;
				end
			end
			S_DADD, S_SADD: begin
				sum_q <= sum_q + SUM_W'(rnd);
			end
			S_SCHK: begin
				ridx_q <= '0;
			end
			S_RDIV: begin
				// A zero normal leaves the reflected vector as the negated light vector.
				if (k_q != 2'd0 && div_sts.done) begin
					r_q[ridx_q] <= rq - R_W'(l_q[ridx_q]);
					ridx_q      <= ridx_q + 1'b1;
				end
			end
			S_SDEN: begin
				rv_q <= acc_q[MA_W-1:0];
			end
			S_SDIV: begin
				if (k_q == 2'd0) begin
					dz_q <= (prod_q[DEN_W-1:0] == '0);
				end else if (div_sts.done) begin
					cos_q  <= cosv;
					pow_q  <= Q16_ONE;
					pidx_q <= PIDX_W'(EXP_BITS - 1);
				end
			end
			S_PSQW: begin
				pow_q <= rnd;
				if (!spec_q[pidx_q] && pidx_q != '0) begin
					pidx_q <= pidx_q - 1'b1;
				end
			end
			S_PMCW: begin
				pow_q <= rnd;
				if (pidx_q != '0) begin
					pidx_q <= pidx_q - 1'b1;
				end
			end
			S_ACC: begin
				if (last_q && out_free) begin
					res_q <= tclamp;
				end
			end
			default: begin
				dz_q <= dz_q;
			end
		endcase
	end

	`PLC_ASSERT(a_result_from_acc, $rose(res_valid_q) |-> $past(state_q == S_ACC),
		"result raised outside the accumulate step")
	`PLC_ASSERT_NEXT(a_emit_clears, state_q == S_ACC && last_q && out_free,
		accum_q == '0 && res_valid_q, "emitted sum not cleared")
	`PLC_ASSERT(a_idle_units_quiet, state_q == S_IDLE |-> !sqrt_sts.busy && !div_sts.busy,
		"arithmetic unit busy while accepting transactions")

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import plc_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int N_EXP = 10;
	localparam longint FIT_LIM = 32768;
	localparam longint ONE_Q = 65536;
	localparam int DRAIN_CYCLES = 1000;

	typedef longint vec_t [3];

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [2:0] op;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic [INTEN_W-1:0] light_intensity;
	logic [N_EXP-1:0] specular_exp;
	logic shadowed;
	logic last_light;
	logic result_valid;
	logic result_stall;
	logic [INTEN_W-1:0] total_intensity;

	phong_light_accumulate dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.op(op), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.light_intensity(light_intensity), .specular_exp(specular_exp),
		.shadowed(shadowed), .last_light(last_light),
		.result_valid(result_valid), .result_stall(result_stall),
		.total_intensity(total_intensity)
	);

	// Predicted state of the shader.
	vec_t pt_m, nrm_m, view_m;
	int unsigned spec_m;
	longint unsigned sum_m;
	longint unsigned intensity_q[$];

	int errors;
	int burst_left;
	int hold_seq;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#200ms;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic longint unsigned mag(input longint v);
		return v < 0 ? 64'd0 - longint'(unsigned'(v)) : unsigned'(v);
	endfunction

	function automatic void fit_vec(input vec_t a, input bit negate, output vec_t o);
		longint unsigned m[3];
		longint unsigned mx;
		int s;
		longint q;
		mx = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(a[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		while ((mx >> s) >= FIT_LIM)
			s++;
		for (int i = 0; i < 3; i++) begin
			q = longint'(m[i] >> s);
			o[i] = ((a[i] < 0) != negate) ? -q : q;
		end
	endfunction

	function automatic longint dot(input vec_t a, input vec_t b);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic longint unsigned root(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned len(input vec_t a);
		return root(unsigned'(dot(a, a)));
	endfunction

	function automatic longint unsigned cosine(input longint d, input longint unsigned la,
			input longint unsigned lb);
		longint unsigned den, c;
		den = la * lb;
		if (den == 0)
			return 0;
		c = (unsigned'(d) * ONE_Q) / den;
		return c > ONE_Q ? ONE_Q : c;
	endfunction

	function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
		return (a * b + 32768) >> 16;
	endfunction

	function automatic longint unsigned qpow(input longint unsigned c, input int unsigned e);
		longint unsigned r;
		r = ONE_Q;
		for (int i = N_EXP - 1; i >= 0; i--) begin
			r = qmul(r, r);
			if ((e >> i) & 1)
				r = qmul(r, c);
		end
		return r;
	endfunction

	function automatic longint unsigned phong_term(input vec_t pos, input longint unsigned inten);
		vec_t lraw, l, n, v, r;
		longint nl, nn, rv;
		longint unsigned s;
		s = 0;
		for (int i = 0; i < 3; i++)
			lraw[i] = pos[i] - pt_m[i];
		fit_vec(lraw, 1'b0, l);
		fit_vec(nrm_m, 1'b0, n);
		nl = dot(n, l);
		if (nl > 0)
			s += (inten * cosine(nl, len(n), len(l)) + 32768) >> 16;
		if (spec_m > 0) begin
			nn = dot(n, n);
			for (int i = 0; i < 3; i++)
				r[i] = (nn != 0 ? (2 * n[i] * nl) / nn : 0) - l[i];
			fit_vec(view_m, 1'b1, v);
			rv = dot(r, v);
			if (rv > 0)
				s += (inten * qpow(cosine(rv, len(r), len(v)), spec_m) + 32768) >> 16;
		end
		return s;
	endfunction

	function automatic void shade_item(input logic [2:0] o, input vec_t c,
			input longint unsigned inten, input int unsigned e, input bit sh, input bit lst);
		longint unsigned a;
		case (o)
			OP_POINT: pt_m = c;
			OP_NORMAL: nrm_m = c;
			OP_VIEW: begin
				view_m = c;
				spec_m = e;
			end
			OP_AMBIENT, OP_LIGHT: begin
				a = sum_m;
				if (o == OP_AMBIENT)
					a += inten;
				else if (!sh)
					a += phong_term(c, inten);
				if (a > ONE_Q)
					a = ONE_Q;
				sum_m = a;
				if (lst) begin
					intensity_q.push_back(a);
					sum_m = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// Offers one transaction and waits until it is taken; called on a rising edge.
	task automatic send(input logic [2:0] o, input int x, input int y, input int z,
			input int unsigned inten, input int unsigned e, input bit sh, input bit lst);
		vec_t c;
		c[0] = x;
		c[1] = y;
		c[2] = z;
		op <= o;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		light_intensity <= INTEN_W'(inten);
		specular_exp <= N_EXP'(e);
		shadowed <= sh;
		last_light <= lst;
		item_valid <= 1'b1;
		forever begin
			@(negedge clk);
			if (!item_stall) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		shade_item(o, c, inten, e, sh, lst);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 30);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_paced(input logic [2:0] o, input int x, input int y, input int z,
			input int unsigned inten, input int unsigned e, input bit sh, input bit lst);
		send(o, x, y, z, inten, e, sh, lst);
		pace();
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (intensity_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: a free-running counter picks a new random stall pattern; a requested hold overrides it.
	int rx_mode, rx_cnt, hold_cnt, hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_mode <= 0;
			rx_cnt <= 0;
			hold_cnt <= 0;
			hold_seen <= 0;
		end else begin
			if (hold_seen != hold_seq) begin
				hold_seen <= hold_seq;
				hold_cnt <= 3000;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
			end
			rx_cnt <= rx_cnt + 1;
			if (rx_cnt % 64 == 0)
				rx_mode <= $urandom_range(0, 2);
			if (hold_cnt > 0 || hold_seen != hold_seq)
				result_stall <= 1'b1;
			else if (rx_mode == 1)
				result_stall <= ($urandom_range(0, 9) < 4);
			else if (rx_mode == 2)
				result_stall <= rx_cnt[0];
			else
				result_stall <= 1'b0;
		end
	end

	// A result is taken at the next rising edge when valid is high and stall is low.
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (intensity_q.size() == 0) begin
				report($sformatf("unexpected result %0d", total_intensity));
			end else begin
				if (total_intensity !== intensity_q[0][INTEN_W-1:0])
					report($sformatf("total_intensity %0d, predicted %0d",
						total_intensity, intensity_q[0]));
				void'(intensity_q.pop_front());
			end
		end
	end

	function automatic int rnd_coord();
		case ($urandom_range(0, 3))
			0: return int'($urandom());
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return int'($urandom_range(0, 20'hfffff)) - 20'h80000;
		endcase
	endfunction

	task automatic test_loads_and_ambient();
		send(OP_AMBIENT, 0, 0, 0, 0, 0, 0, 1);
		send(OP_AMBIENT, 0, 0, 0, 1, 0, 0, 0);
		send(OP_AMBIENT, 0, 0, 0, 65536, 0, 0, 1);
		send(OP_AMBIENT, 0, 0, 0, 17'h1ffff, 0, 1, 1);
		send(OP_POINT, 32'sh7fffffff, 32'sh80000000, 0, 17'h1ffff, 1023, 1, 1);
		send(OP_NORMAL, 0, 0, 65536, 0, 0, 0, 1);
		send(OP_VIEW, 0, 0, -65536, 0, 0, 0, 1);
		send(OP_SPARE_LO, 5, 6, 7, 5000, 3, 0, 1);
		send(OP_SPARE_HI, -1, -1, -1, 17'h1ffff, 1023, 1, 1);
		wait_idle();
	endtask

	task automatic test_point_lights();
		send(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
		send(OP_NORMAL, 0, 0, 65536, 0, 0, 0, 0);
		send(OP_VIEW, 0, 0, -65536, 0, 0, 0, 0);
		send(OP_LIGHT, 0, 0, 65536 * 5, 40000, 0, 0, 1);
		send(OP_LIGHT, 0, 0, 0, 65536, 0, 0, 1);
		send(OP_LIGHT, 65536, 0, 65536, 65536, 0, 1, 1);
		send(OP_VIEW, 65536, 0, -65536, 0, 1023, 0, 0);
		send(OP_LIGHT, -65536, 0, 65536, 65536, 0, 0, 1);
		send(OP_VIEW, 0, 65536, -65536, 0, 1, 0, 0);
		send(OP_LIGHT, 0, -65536, 65536, 17'h1ffff, 0, 0, 0);
		send(OP_NORMAL, 0, 0, 0, 0, 0, 0, 0);
		send(OP_LIGHT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 65536, 0, 0, 1);
		send(OP_VIEW, 0, 0, 0, 0, 7, 0, 0);
		send(OP_NORMAL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
		send(OP_LIGHT, 32'sh80000000, 32'sh7fffffff, 0, 30000, 0, 0, 1);
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_seq++;
		for (int i = 0; i < 20; i++)
			send(OP_AMBIENT, 0, 0, 0, $urandom_range(0, 65536), 0, 0, 1);
		wait_idle();
	endtask

	task automatic test_random_scenes();
		int items, nl;
		items = 0;
		while (items < 1900) begin
			if ($urandom_range(0, 9) == 0) begin
				send_paced(3'($urandom_range(0, 7)), int'($urandom()), int'($urandom()),
					int'($urandom()), $urandom_range(0, 17'h1ffff), $urandom_range(0, 1023),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				items++;
			end else begin
				send_paced(OP_POINT, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0, 0, 0);
				items++;
				if ($urandom_range(0, 7) != 0) begin
					send_paced(OP_NORMAL, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0, 0, 0);
					items++;
				end
				if ($urandom_range(0, 3) != 0) begin
					send_paced(OP_VIEW, rnd_coord(), rnd_coord(), rnd_coord(), 0,
						$urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 1023), 0, 0);
					items++;
				end
				nl = $urandom_range(1, 4);
				for (int k = 0; k < nl; k++)
					send_paced($urandom_range(0, 3) == 0 ? OP_AMBIENT : OP_LIGHT, rnd_coord(),
						rnd_coord(), rnd_coord(),
						$urandom_range(0, 7) == 0 ? $urandom_range(65537, 17'h1ffff)
							: $urandom_range(0, 65536),
						$urandom_range(0, 1023), $urandom_range(0, 4) == 0, k == nl - 1);
				items += nl;
			end
		end
		wait_idle();
	endtask

	initial begin
		errors = 0;
		burst_left = 0;
		hold_seq = 0;
		pt_m = '{0, 0, 0};
		nrm_m = '{0, 0, 0};
		view_m = '{0, 0, 0};
		spec_m = 0;
		sum_m = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		op = OP_POINT;
		coord_x = 0;
		coord_y = 0;
		coord_z = 0;
		light_intensity = 0;
		specular_exp = 0;
		shadowed = 1'b0;
		last_light = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_loads_and_ambient();
		test_point_lights();
		test_backpressure();
		test_random_scenes();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_isqrt.sv
rtl/plc_div.sv
rtl/phong_light_accumulate.sv
tb/sv/tb_top.sv
